// ===== design/vn_pkg.sv =====
// Shared types, widths and arithmetic step functions for the vector normalizer.
// Used by vn_sqrt, vn_div and vector3_normalize; depends on nothing else.
`default_nettype none
package vn_pkg;

    localparam int CW      = 16;
    localparam int FB      = 15;
    localparam int OUT_W   = FB + 1;
    localparam int TOL_W   = 16;
    localparam int SUM_W   = 2 * CW;
    localparam int REM_W   = CW + 3;
    localparam int SQ_PER  = 2;
    localparam int SQ_ST   = (CW + SQ_PER - 1) / SQ_PER;
    localparam int DV_PER  = 3;
    localparam int DV_ST   = (FB + DV_PER - 1) / DV_PER;

    typedef struct packed {
        logic [CW-1:0] mag_x;
        logic [CW-1:0] mag_y;
        logic [CW-1:0] mag_z;
        logic          neg_x;
        logic          neg_y;
        logic          neg_z;
    } t_side;

    typedef struct packed {
        logic [SUM_W-1:0] n;
        logic [CW-1:0]    root;
        logic [REM_W-1:0] rem;
    } t_sq_st;

    typedef struct packed {
        logic [CW-1:0] rem;
        logic [FB-1:0] q;
        logic [CW-1:0] len;
        logic          sat;
        logic          neg;
    } t_dv;

    function automatic t_sq_st sq_step(input t_sq_st a);
        t_sq_st           r;
        logic [REM_W-1:0] rem_t;
        logic [REM_W-1:0] trial;
        r     = a;
        rem_t = {a.rem[REM_W-3:0], a.n[SUM_W-1 -: 2]};
        trial = {1'b0, a.root, 2'b01};
        r.n   = {a.n[SUM_W-3:0], 2'b00};
        if (rem_t >= trial) begin
            r.rem  = rem_t - trial;
            r.root = {a.root[CW-2:0], 1'b1};
        end else begin
            r.rem  = rem_t;
            r.root = {a.root[CW-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic t_dv dv_step(input t_dv a);
        t_dv         r;
        logic [CW:0] t;
        r = a;
        t = {a.rem, 1'b0};
        if (t >= {1'b0, a.len}) begin
            r.rem = CW'(t - {1'b0, a.len});
            r.q   = {a.q[FB-2:0], 1'b1};
        end else begin
            r.rem = t[CW-1:0];
            r.q   = {a.q[FB-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/vn_sqrt.sv =====
// Pipelined digit-by-digit integer square root, two result bits per stage.
// Carries the vector side data alongside; depends on vn_pkg.
`default_nettype none
module vn_sqrt (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_en,
    input  wire                     i_valid,
    input  wire [vn_pkg::SUM_W-1:0] i_sum,
    input  vn_pkg::t_side           i_side,
    output logic                    o_valid,
    output logic [vn_pkg::CW-1:0]   o_len,
    output vn_pkg::t_side           o_side
);
    import vn_pkg::*;

    logic   r_vld  [SQ_ST];
    t_sq_st r_st   [SQ_ST];
    t_side  r_side [SQ_ST];

    for (genvar s = 0; s < SQ_ST; s++) begin : g_st
        t_sq_st w_in;
        t_sq_st w_out;
        logic   w_vld;
        t_side  w_side;

        if (s == 0) begin : g_first
            assign w_in   = '{n: i_sum, root: '0, rem: '0};
            assign w_vld  = i_valid;
            assign w_side = i_side;
        end else begin : g_next
            assign w_in   = r_st[s-1];
            assign w_vld  = r_vld[s-1];
            assign w_side = r_side[s-1];
        end

        always_comb begin
            w_out = w_in;
            for (int j = 0; j < SQ_PER; j++) begin
                if (s * SQ_PER + j < CW) begin
                    w_out = sq_step(w_out);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld;
            end
            if (i_en) begin
                r_st[s]   <= w_out;
                r_side[s] <= w_side;
            end
        end
    end

    assign o_valid = r_vld[SQ_ST-1];
    assign o_len   = r_st[SQ_ST-1].root;
    assign o_side  = r_side[SQ_ST-1];

endmodule
`default_nettype wire

// ===== design/vn_div.sv =====
// Pipelined restoring divider for one component: |c| * 2^FB / len, three bits per stage.
// Flags saturation when the magnitude reaches the length; depends on vn_pkg.
`default_nettype none
module vn_div (
    input  wire                   i_clk,
    input  wire                   i_en,
    input  wire [vn_pkg::CW-1:0]  i_mag,
    input  wire                   i_neg,
    input  wire [vn_pkg::CW-1:0]  i_len,
    output logic [vn_pkg::FB-1:0] o_q,
    output logic                  o_sat,
    output logic                  o_neg
);
    import vn_pkg::*;

    t_dv r_st [DV_ST];

    for (genvar s = 0; s < DV_ST; s++) begin : g_st
        t_dv w_in;
        t_dv w_out;

        if (s == 0) begin : g_first
            assign w_in = '{rem: i_mag, q: '0, len: i_len, sat: (i_mag >= i_len), neg: i_neg};
        end else begin : g_next
            assign w_in = r_st[s-1];
        end

        always_comb begin
            w_out = w_in;
            for (int j = 0; j < DV_PER; j++) begin
                if (s * DV_PER + j < FB) begin
                    w_out = dv_step(w_out);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[s] <= w_out;
            end
        end
    end

    assign o_q   = r_st[DV_ST-1].q;
    assign o_sat = r_st[DV_ST-1].sat;
    assign o_neg = r_st[DV_ST-1].neg;

endmodule
`default_nettype wire

// ===== design/vector3_normalize.sv =====
// From input word to output word the pipeline has magnitude, square and sum stages,
// eight square root stages, five divider stages and one output register.
// Throughput is one word per cycle; an output stall freezes the whole pipeline.
// Synchronous active-low reset clears all valid bits and sets the zero tolerance to 1.
// Depends on vn_pkg, vn_sqrt and vn_div.
`default_nettype none
module vector3_normalize (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_stall,
    input  wire signed [vn_pkg::CW-1:0] i_vec_x,
    input  wire signed [vn_pkg::CW-1:0] i_vec_y,
    input  wire signed [vn_pkg::CW-1:0] i_vec_z,
    output logic                        o_valid,
    input  wire                         i_stall,
    output logic signed [vn_pkg::OUT_W-1:0] o_norm_x,
    output logic signed [vn_pkg::OUT_W-1:0] o_norm_y,
    output logic signed [vn_pkg::OUT_W-1:0] o_norm_z,
    output logic                        o_was_zero,
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire [vn_pkg::TOL_W-1:0]     i_cfg_data
);
    import vn_pkg::*;

    logic             w_en;
    logic [TOL_W-1:0] r_tol;

    logic             r_v1;
    t_side            r_side1;
    logic             r_v2;
    t_side            r_side2;
    logic [SUM_W-1:0] r_sqx, r_sqy, r_sqz;
    logic             r_v3;
    t_side            r_side3;
    logic [SUM_W-1:0] r_sum;

    logic             w_sq_vld;
    logic [CW-1:0]    w_len;
    t_side            w_side;

    logic             r_dvld [DV_ST];
    logic             r_dzero[DV_ST];

    logic [FB-1:0]    w_qx, w_qy, w_qz;
    logic             w_sx, w_sy, w_sz;
    logic             w_nx, w_ny, w_nz;

    logic             r_out_vld;
    logic [OUT_W-1:0] r_nx, r_ny, r_nz;
    logic             r_zero;

    assign w_en        = !(r_out_vld && i_stall);
    assign o_stall     = !w_en;
    assign o_cfg_ready = 1'b1;

    function automatic logic [OUT_W-1:0] fmt(input logic [FB-1:0] q, input logic sat,
                                            input logic neg, input logic zero);
        logic [OUT_W-1:0] r;
        if (zero) begin
            r = '0;
        end else if (sat) begin
            r = neg ? {1'b1, {FB{1'b0}}} : {1'b0, {FB{1'b1}}};
        end else begin
            r = neg ? OUT_W'(-{1'b0, q}) : {1'b0, q};
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tol <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        if (w_en) begin
            r_side1.neg_x <= i_vec_x[CW-1];
            r_side1.neg_y <= i_vec_y[CW-1];
            r_side1.neg_z <= i_vec_z[CW-1];
            r_side1.mag_x <= i_vec_x[CW-1] ? CW'(-i_vec_x) : i_vec_x;
            r_side1.mag_y <= i_vec_y[CW-1] ? CW'(-i_vec_y) : i_vec_y;
            r_side1.mag_z <= i_vec_z[CW-1] ? CW'(-i_vec_z) : i_vec_z;
            r_side2 <= r_side1;
            r_sqx   <= SUM_W'(r_side1.mag_x) * SUM_W'(r_side1.mag_x);
            r_sqy   <= SUM_W'(r_side1.mag_y) * SUM_W'(r_side1.mag_y);
            r_sqz   <= SUM_W'(r_side1.mag_z) * SUM_W'(r_side1.mag_z);
            r_side3 <= r_side2;
            r_sum   <= r_sqx + r_sqy + r_sqz;
        end
    end

    vn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v3),
        .i_sum   (r_sum),
        .i_side  (r_side3),
        .o_valid (w_sq_vld),
        .o_len   (w_len),
        .o_side  (w_side)
    );

    vn_div u_div_x (
        .i_clk (i_clk), .i_en (w_en), .i_mag (w_side.mag_x), .i_neg (w_side.neg_x),
        .i_len (w_len), .o_q (w_qx), .o_sat (w_sx), .o_neg (w_nx)
    );
    vn_div u_div_y (
        .i_clk (i_clk), .i_en (w_en), .i_mag (w_side.mag_y), .i_neg (w_side.neg_y),
        .i_len (w_len), .o_q (w_qy), .o_sat (w_sy), .o_neg (w_ny)
    );
    vn_div u_div_z (
        .i_clk (i_clk), .i_en (w_en), .i_mag (w_side.mag_z), .i_neg (w_side.neg_z),
        .i_len (w_len), .o_q (w_qz), .o_sat (w_sz), .o_neg (w_nz)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DV_ST; s++) begin
                r_dvld[s] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_dvld[0] <= w_sq_vld;
            for (int s = 1; s < DV_ST; s++) begin
                r_dvld[s] <= r_dvld[s-1];
            end
            r_out_vld <= r_dvld[DV_ST-1];
        end
        if (w_en) begin
            r_dzero[0] <= (w_len < r_tol) || (w_len == '0);
            for (int s = 1; s < DV_ST; s++) begin
                r_dzero[s] <= r_dzero[s-1];
            end
            r_zero <= r_dzero[DV_ST-1];
            r_nx   <= fmt(w_qx, w_sx, w_nx, r_dzero[DV_ST-1]);
            r_ny   <= fmt(w_qy, w_sy, w_ny, r_dzero[DV_ST-1]);
            r_nz   <= fmt(w_qz, w_sz, w_nz, r_dzero[DV_ST-1]);
        end
    end

    assign o_valid    = r_out_vld;
    assign o_norm_x   = r_nx;
    assign o_norm_y   = r_ny;
    assign o_norm_z   = r_nz;
    assign o_was_zero = r_zero;

    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_was_zero) |-> (o_norm_x == '0 && o_norm_y == '0 && o_norm_z == '0))
        else $error("Zero flag set with a nonzero component.");

    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_stall) |-> o_stall)
        else $error("Input taken while the output word is held.");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cfg_valid && o_cfg_ready && i_rst_n) |-> (r_tol == $past(i_cfg_data)))
        else $error("Tolerance register missed a write.");

endmodule
`default_nettype wire

// ===== test/vector3_normalize_test.sv =====
// Self-checking testbench for vector3_normalize: directed vectors, then random ones.
// Predicts every normalized word and compares it in order; depends on vn_pkg and the design.
`default_nettype none
module vector3_normalize_test;
    timeunit 1ns;
    timeprecision 1ps;
    import vn_pkg::*;

    localparam int LATENCY   = 17;
    localparam int N_RANDOM  = 630;
    localparam int LIMIT_CYC = 400000;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_vec;

    typedef struct packed {
        logic signed [OUT_W-1:0] nx;
        logic signed [OUT_W-1:0] ny;
        logic signed [OUT_W-1:0] nz;
        logic                    zero;
        logic                    typed;
    } t_unit;

    typedef struct {
        t_vec  v;
        t_unit want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [CW-1:0] i_vec_x = '0;
    logic signed [CW-1:0] i_vec_y = '0;
    logic signed [CW-1:0] i_vec_z = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [OUT_W-1:0] o_norm_x;
    logic signed [OUT_W-1:0] o_norm_y;
    logic signed [OUT_W-1:0] o_norm_z;
    logic o_was_zero;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [TOL_W-1:0] i_cfg_data = '0;

    vector3_normalize dut (.*);

    always #4 i_clk = ~i_clk;

    logic [TOL_W-1:0] tolerance = 1;
    t_unit            pending[$];
    int               errors = 0;
    int               cycles = 0;
    int               n_sent = 0;
    int               n_zero = 0;
    int               n_got = 0;
    bit               calm = 1'b0;
    bit               hold_out = 1'b0;

    function automatic logic [63:0] root_floor(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            b = r | (64'd1 << i);
            if (b * b <= n) r = b;
        end
        return r;
    endfunction

    function automatic logic signed [OUT_W-1:0] to_fraction(input logic signed [CW-1:0] c,
                                                            input logic [63:0] len);
        logic [63:0] mag;
        logic [63:0] q;
        mag = (c < 0) ? 64'(-64'(c)) : 64'(c);
        q = (mag << FB) / len;
        if (c < 0) begin
            if (q > (64'd1 << FB)) q = 64'd1 << FB;
            return OUT_W'(-q);
        end
        if (q > (64'd1 << FB) - 1) q = (64'd1 << FB) - 1;
        return OUT_W'(q);
    endfunction

    function automatic t_unit normalize(input t_vec v);
        t_unit       u;
        logic [63:0] len;
        len = root_floor(64'(64'(v.x) * 64'(v.x) + 64'(v.y) * 64'(v.y)
                             + 64'(v.z) * 64'(v.z)));
        u = '0;
        if (len < tolerance || len == 0) begin
            u.zero = 1'b1;
        end else begin
            u.nx = to_fraction(v.x, len);
            u.ny = to_fraction(v.y, len);
            u.nz = to_fraction(v.z, len);
        end
        return u;
    endfunction

    task automatic send(input t_vec v, input t_unit typed_want);
        t_unit u;
        while (!calm && $urandom_range(99) < 13) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_vec_x <= v.x;
        i_vec_y <= v.y;
        i_vec_z <= v.z;
        u = normalize(v);
        if (typed_want.typed && {u.nx, u.ny, u.nz, u.zero} !=
            {typed_want.nx, typed_want.ny, typed_want.nz, typed_want.zero}) begin
            $error("directed row disagrees with predictor for %0d %0d %0d", v.x, v.y, v.z);
            errors++;
        end
        do @(posedge i_clk); while (o_stall);
        pending.push_back(u);
        n_sent++;
        if (u.zero) n_zero++;
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] t);
        i_valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= t;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tolerance = t;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYC) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            n_got++;
            if (pending.size() == 0) begin
                $error("unexpected word: %0d %0d %0d", o_norm_x, o_norm_y, o_norm_z);
                errors++;
            end else begin
                t_unit w;
                w = pending.pop_front();
                if (o_norm_x !== w.nx) begin
                    $error("norm_x expected %0d actual %0d", w.nx, o_norm_x); errors++;
                end
                if (o_norm_y !== w.ny) begin
                    $error("norm_y expected %0d actual %0d", w.ny, o_norm_y); errors++;
                end
                if (o_norm_z !== w.nz) begin
                    $error("norm_z expected %0d actual %0d", w.nz, o_norm_z); errors++;
                end
                if (o_was_zero !== w.zero) begin
                    $error("was_zero expected %0d actual %0d", w.zero, o_was_zero); errors++;
                end
            end
        end
        i_stall <= hold_out || (!calm && $urandom_range(99) < 13);
    end

    function automatic t_unit typed(input int nx, input int ny, input int nz, input bit z);
        t_unit u;
        u.nx = OUT_W'(nx); u.ny = OUT_W'(ny); u.nz = OUT_W'(nz); u.zero = z; u.typed = 1'b1;
        return u;
    endfunction

    function automatic t_vec rand_vec();
        t_vec v;
        int   span;
        span = $urandom_range(3);
        v.x = CW'($urandom); v.y = CW'($urandom); v.z = CW'($urandom);
        if (span == 0) begin
            v.x = CW'($signed(CW'($urandom_range(8))) - 4);
            v.y = CW'($signed(CW'($urandom_range(8))) - 4);
            v.z = CW'($signed(CW'($urandom_range(8))) - 4);
        end else if (span == 1) begin
            v.x = v.x >>> $urandom_range(15);
            v.y = v.y >>> $urandom_range(15);
            v.z = v.z >>> $urandom_range(15);
        end
        return v;
    endfunction

    t_row directed[] = '{
        '{'{16'sd0, 16'sd0, 16'sd0}, typed(0, 0, 0, 1)},
        '{'{16'sd1, 16'sd0, 16'sd0}, typed(32767, 0, 0, 0)},
        '{'{-16'sd1, 16'sd0, 16'sd0}, typed(-32768, 0, 0, 0)},
        '{'{16'sd0, 16'sd5, 16'sd0}, typed(0, 32767, 0, 0)},
        '{'{16'sd0, 16'sd0, -16'sd9}, typed(0, 0, -32768, 0)},
        '{'{16'sd1, 16'sd1, 16'sd0}, typed(32767, 32767, 0, 0)},
        '{'{-16'sd1, -16'sd1, -16'sd1}, typed(-32768, -32768, -32768, 0)},
        '{'{16'sd32767, 16'sd0, 16'sd0}, typed(32767, 0, 0, 0)},
        '{'{-16'sd32768, 16'sd0, 16'sd0}, typed(-32768, 0, 0, 0)},
        '{'{-16'sd32768, -16'sd32768, -16'sd32768}, '0},
        '{'{16'sd32767, 16'sd32767, 16'sd32767}, '0},
        '{'{16'sd3, 16'sd4, 16'sd0}, '0},
        '{'{-16'sd3, 16'sd4, 16'sd12}, '0},
        '{'{16'sd100, -16'sd200, 16'sd300}, '0},
        '{'{16'sd21845, -16'sd10923, 16'sd1}, '0}
    };

    initial begin
        t_vec v;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        calm = 1'b1;
        foreach (directed[i]) send(directed[i].v, directed[i].want);
        calm = 1'b0;
        write_tolerance(TOL_W'(0));
        send('{16'sd0, 16'sd0, 16'sd0}, typed(0, 0, 0, 1));
        send('{16'sd0, 16'sd2, 16'sd0}, typed(0, 32767, 0, 0));
        write_tolerance(16'hFFFF);
        send('{-16'sd32768, -16'sd32768, -16'sd32768}, '0);
        send('{16'sd1000, 16'sd0, 16'sd0}, typed(0, 0, 0, 1));
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 160 == 0) begin
                case (i / 160)
                    0: write_tolerance(TOL_W'($urandom_range(40)));
                    1: write_tolerance(TOL_W'(1));
                    2: write_tolerance(TOL_W'($urandom_range(20000)));
                    default: write_tolerance(TOL_W'($urandom));
                endcase
            end
            calm = (i >= 200 && i < 260);
            if (i == 300) begin
                fork
                    begin
                        hold_out = 1'b1;
                        repeat (60) @(posedge i_clk);
                        hold_out = 1'b0;
                    end
                join_none
            end
            v = rand_vec();
            send(v, '0);
        end
        i_valid <= 1'b0;
        calm = 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        $display("Covered %0d vectors (%0d below tolerance), %0d words checked,",
                 n_sent, n_zero, n_got);
        $display("across several tolerance settings including 0 and 65535.");
        if (errors == 0 && pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
design/vn_pkg.sv
design/vn_sqrt.sv
design/vn_div.sv
design/vector3_normalize.sv
test/vector3_normalize_test.sv
